// File: hdl/fpra_pkg.sv
// Shared types and constants for the fixed-point RNE ALU.
// No dependencies; imported by every module of the block.
package fpra_pkg;

	typedef enum logic [2:0] {
		OP_MULQ  = 3'd0,
		OP_MULSC = 3'd1,
		OP_DIVQ  = 3'd2,
		OP_LERP  = 3'd3,
		OP_SADD  = 3'd4,
		OP_SSUB  = 3'd5,
		OP_VEL   = 3'd6,
		OP_RSVD  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2,
		ST_RSVD = 2'd3
	} st_t;

	localparam int QDEPTH    = 4;
	localparam int DIV_STEPS = 32;
	localparam logic [9:0] INV_STEP_RST = 10'd60;
	localparam logic signed [31:0] S32_LO = 32'sh8000_0000;
	localparam logic signed [31:0] S32_HI = 32'sh7FFF_FFFF;

	// classified item, front to back
	typedef struct packed {
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic        [31:0] ma;
		logic        [31:0] md;
		logic               neg;
		logic               bz;
	} item_t;

	// one stage of the back end after the product stage
	typedef struct packed {
		logic               v;
		op_t                op;
		logic signed [31:0] res;
		st_t                st;
		logic        [31:0] rem;
		logic        [31:0] quo;
		logic        [31:0] md;
		logic               neg;
	} stage_t;

endpackage

// File: hdl/fpra_front.sv
// Front end: decodes the command and prepares operands for the back end.
// Depends on fpra_pkg.
module fpra_front (
	input  logic [2:0]           command,
	input  logic signed [31:0]   operand_a,
	input  logic signed [31:0]   operand_b,
	input  logic signed [31:0]   operand_c,
	input  logic [9:0]           inv_step,
	output fpra_pkg::item_t      item
);
	import fpra_pkg::*;

	logic signed [31:0] diff;

	assign diff = operand_b - operand_a;

	always_comb begin
		item.op  = op_t'(command);
		item.a   = operand_a;
		item.b   = operand_b;
		item.ma  = operand_a[31] ? 32'(-operand_a) : operand_a;
		item.md  = operand_b[31] ? 32'(-operand_b) : operand_b;
		item.neg = operand_a[31] ^ operand_b[31];
		item.bz  = (operand_b == 32'sd0);
		unique case (op_t'(command))
			OP_LERP: begin
				item.mx = diff;
				item.my = operand_c;
			end
			OP_VEL: begin
				item.mx = operand_a;
				item.my = {22'd0, inv_step};
			end
			default: begin
				item.mx = operand_a;
				item.my = operand_b;
			end
		endcase
	end

endmodule

// File: hdl/fpra_queue.sv
// Short queue between front and back end.
// Depends on fpra_pkg.
module fpra_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  fpra_pkg::item_t      wdata,
	output logic                 full,
	input  logic                 rd,
	output fpra_pkg::item_t      rdata,
	output logic                 empty
);
	import fpra_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	item_t           mem_q [QDEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wr_q <= wr_q + 1'b1;
			if (do_rd) rd_q <= rd_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_q] <= wdata;
	end

endmodule

// File: hdl/fpra_back.sv
// Back end: multiplier stage, rounding stage, pipelined restoring divider.
// Depends on fpra_pkg.
module fpra_back #(
	parameter int unsigned Q_FRAC      = 30,
	parameter int unsigned SCALAR_FRAC = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  fpra_pkg::item_t      item,
	output logic                 take,
	output logic                 out_valid,
	output logic signed [31:0]   out_result,
	output logic [1:0]           out_status,
	input  logic                 out_pop
);
	import fpra_pkg::*;

	function automatic logic signed [63:0] rne(logic signed [63:0] p, int unsigned k);
		logic signed [63:0] hi;
		logic [63:0] mask;
		logic [63:0] rem;
		logic [63:0] half;
		begin
			hi   = p >>> k;
			mask = (64'd1 << k) - 64'd1;
			rem  = 64'(p) & mask;
			half = 64'd1 << (k - 1);
			if (rem > half || (rem == half && hi[0])) hi = hi + 64'sd1;
			return hi;
		end
	endfunction

	function automatic stage_t div_step(stage_t s);
		stage_t n;
		logic [32:0] rr;
		logic [32:0] dd;
		logic        ge;
		begin
			n  = s;
			rr = {s.rem, s.quo[31]};
			dd = rr - {1'b0, s.md};
			ge = (rr >= {1'b0, s.md});
			if (s.op == OP_DIVQ && s.st == ST_OK) begin
				n.rem = ge ? dd[31:0] : rr[31:0];
				n.quo = {s.quo[30:0], ge};
			end
			return n;
		end
	endfunction

	// global advance: whole back end moves when the output slot frees
	logic adv;
	assign adv  = !out_valid || out_pop;
	assign take = adv && in_valid;

	// ---- stage 1: product, saturating add, divider setup
	logic               v_s1;
	op_t                op_s1;
	logic signed [31:0] a_s1;
	logic signed [63:0] prod_s1;
	logic signed [31:0] res_s1;
	st_t                st_s1;
	logic [31:0]        rem_s1;
	logic [31:0]        lo_s1;
	logic [31:0]        md_s1;
	logic               neg_s1;

	logic signed [32:0] sum33;
	logic signed [31:0] sat;
	logic [63:0]        mn;
	st_t                dst;

	always_comb begin
		sum33 = (item.op == OP_SSUB) ? ({item.a[31], item.a} - {item.b[31], item.b})
		                             : ({item.a[31], item.a} + {item.b[31], item.b});
		if (sum33[32] != sum33[31]) sat = sum33[32] ? S32_LO : S32_HI;
		else                        sat = sum33[31:0];
		mn = {32'd0, item.ma} << Q_FRAC;
		priority if (item.bz)              dst = ST_DIVZ;
		else if (mn[63:32] >= item.md)     dst = ST_OVF;
		else                               dst = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= item.op;
			a_s1    <= item.a;
			prod_s1 <= item.mx * item.my;
			res_s1  <= (item.op == OP_SADD || item.op == OP_SSUB) ? sat : 32'sd0;
			st_s1   <= (item.op == OP_DIVQ) ? dst : ST_OK;
			rem_s1  <= mn[63:32];
			lo_s1   <= mn[31:0];
			md_s1   <= item.md;
			neg_s1  <= item.neg;
		end
	end

	// ---- stage 2: rounding and range check of products
	stage_t             nx2;
	logic signed [63:0] rq;
	logic signed [64:0] wide;
	logic               is_mul;
	logic               fits;

	always_comb begin
		rq     = rne(prod_s1, (op_s1 == OP_MULSC) ? SCALAR_FRAC : Q_FRAC);
		is_mul = 1'b1;
		unique case (op_s1)
			OP_MULQ, OP_MULSC: wide = {rq[63], rq};
			OP_LERP:           wide = {rq[63], rq} + {{33{a_s1[31]}}, a_s1};
			OP_VEL:            wide = {prod_s1[63], prod_s1[61:0], 2'b00};
			default: begin
				wide   = '0;
				is_mul = 1'b0;
			end
		endcase
		fits = (wide[64:31] == '0) || (wide[64:31] == '1);
		nx2.v   = v_s1;
		nx2.op  = op_s1;
		nx2.rem = rem_s1;
		nx2.quo = lo_s1;
		nx2.md  = md_s1;
		nx2.neg = neg_s1;
		if (is_mul) begin
			nx2.res = fits ? wide[31:0] : 32'sd0;
			nx2.st  = fits ? ST_OK : ST_OVF;
		end else begin
			nx2.res = res_s1;
			nx2.st  = st_s1;
		end
	end

	// ---- divider pipeline: one quotient bit per stage
	stage_t dpipe_q [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) dpipe_q[i] <= '0;
		end else if (adv) begin
			dpipe_q[0] <= nx2;
			for (int i = 0; i < DIV_STEPS; i++) dpipe_q[i+1] <= div_step(dpipe_q[i]);
		end
	end

	// ---- final: quotient rounding, sign, range check
	stage_t             lst;
	logic [32:0]        r2;
	logic [32:0]        qq;
	logic [32:0]        sq;
	logic               dinc;
	logic               dfit;
	logic signed [31:0] fres;
	st_t                fst;

	always_comb begin
		lst  = dpipe_q[DIV_STEPS];
		r2   = {lst.rem, 1'b0};
		dinc = (r2 > {1'b0, lst.md}) || (r2 == {1'b0, lst.md} && lst.quo[0]);
		qq   = {1'b0, lst.quo} + {32'd0, dinc};
		sq   = lst.neg ? (33'd0 - qq) : qq;
		dfit = lst.neg ? (qq <= 33'h0_8000_0000) : (qq <= 33'h0_7FFF_FFFF);
		if (lst.op == OP_DIVQ && lst.st == ST_OK) begin
			fres = dfit ? sq[31:0] : 32'sd0;
			fst  = dfit ? ST_OK : ST_OVF;
		end else begin
			fres = lst.res;
			fst  = lst.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= lst.v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_result <= fres;
			out_status <= fst;
		end
	end

endmodule

// File: hdl/fixed_point_rne_alu.sv
// Top level of the fixed-point RNE ALU: config register, front, queue, back.
// Depends on fpra_pkg, fpra_front, fpra_queue, fpra_back.
//
// Queue-style 32-bit fixed-point ALU. Push a command beat with operands a, b,
// c while full is low; results pop out in order, one result beat per command,
// with status 0 ok, 1 overflow (result 0), 2 divide by zero (result 0). One
// beat per clock is accepted and delivered sustained while pop stays high.
// A pushed command passes through the queue write, one product stage, 33
// divider registers (the rounding of products feeds the first of them; one
// quotient bit per stage, all commands flow through it to keep order) and the
// output register. While a result waits and pop is held low, the whole back
// end holds; the 4-beat queue behind the decoder keeps taking pushes until it
// fills. inv_step sits at byte address 0 of the APB port (reset 60) and
// should only be written while no command is in flight.
module fixed_point_rne_alu #(
	parameter int unsigned Q_FRAC      = 30,
	parameter int unsigned SCALAR_FRAC = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// command side
	input  logic                push,
	output logic                full,
	input  logic [2:0]          command,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	input  logic signed [31:0]  operand_c,
	// result side
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  result,
	output logic [1:0]          status,
	// APB config
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import fpra_pkg::*;

	logic [9:0] inv_step_q;
	item_t      f_item;
	item_t      q_item;
	logic       q_empty;
	logic       b_take;
	logic       b_valid;

	// single register, word index is paddr[2]; byte lanes ignored
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {22'd0, inv_step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_step_q <= INV_STEP_RST;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			inv_step_q <= pwdata[9:0];
		end
	end

	fpra_front u_front (
		.command   (command),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.operand_c (operand_c),
		.inv_step  (inv_step_q),
		.item      (f_item)
	);

	fpra_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (f_item),
		.full   (full),
		.rd     (b_take),
		.rdata  (q_item),
		.empty  (q_empty)
	);

	fpra_back #(
		.Q_FRAC      (Q_FRAC),
		.SCALAR_FRAC (SCALAR_FRAC)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!q_empty),
		.item       (q_item),
		.take       (b_take),
		.out_valid  (b_valid),
		.out_result (result),
		.out_status (status),
		.out_pop    (pop)
	);

	assign empty = !b_valid;

endmodule

// File: hdl/fpra_checker.sv
// Port-level checker for the fixed-point RNE ALU, bound to the top level.
// Depends on fpra_pkg and fixed_point_rne_alu.
module fpra_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [2:0]         command,
	input logic signed [31:0] operand_a,
	input logic signed [31:0] operand_b,
	input logic signed [31:0] operand_c,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] result,
	input logic [1:0]         status,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready
);
	import fpra_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_OK || status == ST_OVF || status == ST_DIVZ))
		else $error("reserved status code on result beat");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (result == 32'sd0))
		else $error("error beat with nonzero result");

	a_divz_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_DIVZ) |-> (result == 32'sd0 && status != ST_OVF))
		else $error("divide-by-zero beat malformed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result) && $stable(status)))
		else $error("result beat changed while stalled");

endmodule

bind fixed_point_rne_alu fpra_checker u_chk (.*);

// File: tb/fixed_point_rne_alu_test.sv
// Self-checking testbench for fixed_point_rne_alu: every command beat is predicted
// in-line and each result beat is compared in order. Depends on fpra_pkg and the
// block's RTL only.
module fixed_point_rne_alu_test;
	import fpra_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 48;   // covers the back-end pipeline depth with margin
	localparam int RANDOM_ITEMS   = 1060;

	typedef struct {
		logic signed [31:0] result;
		st_t                status;
	} alu_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [2:0]         command = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic signed [31:0] operand_c = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [31:0] result;
	logic [1:0]         status;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	alu_answer_t pending_answers[$];
	logic [9:0]  model_inv_step = INV_STEP_RST;
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	bit          no_idling = 1'b0;   // when set, neither side inserts gaps
	int          pop_stall = 0;

	fixed_point_rne_alu DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// floor shift then round half to even on the dropped bits
	function automatic longint round_shift(longint p, int k);
		longint q, rem, half;
		q = p >>> k;
		rem = p - (q <<< k);
		half = longint'(1) <<< (k - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 1;
		return q;
	endfunction

	function automatic longint round_divide(longint n, longint d);
		longint mn, md, q, r;
		bit neg;
		neg = (n < 0) != (d < 0);
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = mn / md;
		r = mn % md;
		if (2 * r > md || (2 * r == md && q[0]))
			q = q + 1;
		return neg ? -q : q;
	endfunction

	function automatic alu_answer_t alu_predict(logic [2:0] cmd, logic signed [31:0] a,
		logic signed [31:0] b, logic signed [31:0] c, logic [9:0] inv_step);
		alu_answer_t ans;
		longint la, lb, r;
		logic signed [31:0] diff;
		bit range_check;
		la = a;
		lb = b;
		r = 0;
		range_check = 1'b1;
		ans.status = ST_OK;
		case (op_t'(cmd))
			OP_MULQ:  r = round_shift(la * lb, 30);
			OP_MULSC: r = round_shift(la * lb, 16);
			OP_DIVQ: begin
				if (lb == 0) begin
					ans.status = ST_DIVZ;
					range_check = 1'b0;
				end else begin
					r = round_divide(la <<< 30, lb);
				end
			end
			OP_LERP: begin
				diff = b - a;   // wraps at 32 bits
				r = la + round_shift(longint'(diff) * longint'(c), 30);
			end
			OP_SADD: r = la + lb;
			OP_SSUB: r = la - lb;
			OP_VEL:  r = la * longint'(inv_step) * 4;
			default: range_check = 1'b0;
		endcase
		if (op_t'(cmd) == OP_SADD || op_t'(cmd) == OP_SSUB) begin
			if (r > longint'(S32_HI)) r = S32_HI;
			if (r < longint'(S32_LO)) r = S32_LO;
		end
		if (range_check && (r > longint'(S32_HI) || r < longint'(S32_LO)))
			ans.status = ST_OVF;
		ans.result = (ans.status == ST_OK) ? r[31:0] : '0;
		return ans;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: predicts on accepted command beats, checks result beats,
	// and tracks the register as written through APB.
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		mismatch_count++;
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
	endtask

	always @(posedge clk) begin
		alu_answer_t want;
		if (arst_n) begin
			if (push && !full)
				pending_answers.push_back(alu_predict(command, operand_a, operand_b,
					operand_c, model_inv_step));
			if (pop && !empty) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("unexpected result beat", result, 0);
				end else begin
					want = pending_answers.pop_front();
					if (result !== want.result)
						report_mismatch("result", result, want.result);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
				end
			end
			if (psel && penable && pwrite && pready && paddr == 3'd0)
				model_inv_step <= pwdata[9:0];
		end
	end

	// watchdog: cycles without any accepted beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idling || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random stalls on pop
	always @(posedge clk) begin
		if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else begin
			pop <= 1'b1;
			pop_stall <= pick_gap();
		end
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// one command beat; push stays high across back-to-back beats
	task automatic send_item(op_t cmd, logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		operand_a <= a;
		operand_b <= b;
		operand_c <= c;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write; only called with the block drained
	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return $urandom();
		if (r < 65) return $signed($urandom_range(0, 32'h8000_0000)) -
			32'sh4000_0000;                                  // about +-1.0 in Q30
		if (r < 85) return $signed($urandom_range(0, 2000)) - 1000;
		case ($urandom_range(0, 5))
			0: return S32_LO;
			1: return S32_HI;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return 32'sh4000_0000;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed();
		send_item(OP_MULQ, S32_LO, S32_LO, 0);                  // overflow
		send_item(OP_MULQ, S32_HI, 32'sh4000_0000, 0);          // times 1.0
		send_item(OP_MULQ, 32'sh2000_0000, 1, 0);               // tie down to even
		send_item(OP_MULQ, 32'sh6000_0000, 1, 0);               // tie up to even
		send_item(OP_MULQ, -32'sh2000_0000, 3, 0);              // negative tie
		send_item(OP_MULSC, S32_LO, -1, 0);
		send_item(OP_MULSC, 32'sh0000_8000, 3, 0);              // tie
		send_item(OP_MULSC, S32_HI, S32_HI, 0);
		send_item(OP_DIVQ, 32'sh1234_5678, 0, 0);               // divide by zero
		send_item(OP_DIVQ, 1, 8, 0);
		send_item(OP_DIVQ, 3, -32'sh8000_0000, 0);
		send_item(OP_DIVQ, S32_LO, 1, 0);                       // overflow
		send_item(OP_DIVQ, -1, 3, 0);
		send_item(OP_LERP, S32_LO, S32_HI, 32'sh2000_0000);
		send_item(OP_LERP, S32_HI, S32_LO, 32'sh4000_0000);     // wrapped delta
		send_item(OP_LERP, 100, -100, S32_LO);
		send_item(OP_SADD, S32_HI, 1, -1);
		send_item(OP_SADD, S32_LO, S32_LO, 0);
		send_item(OP_SSUB, S32_LO, 1, 0);
		send_item(OP_SSUB, S32_HI, S32_LO, 0);
		send_item(OP_VEL, 1000, 0, 0);
		send_item(OP_VEL, S32_HI, 0, 0);                        // overflow
		send_item(OP_RSVD, S32_HI, S32_LO, -1);                 // unused code
		send_item(OP_RSVD, 0, 0, 0);
	endtask

	task automatic test_random(int count);
		repeat (count) begin
			send_item(op_t'($urandom_range(0, 7)), rand_operand(), rand_operand(),
				rand_operand());
		end
	endtask

	task automatic test_inv_step_settings();
		logic [9:0] settings[5] = '{10'd1, 10'd1023, 10'd0, 10'd513, 10'd60};
		foreach (settings[i]) begin
			wait_drained();
			// upper data bits set to show only the low 10 are kept
			reg_write(3'd0, {22'($urandom_range(0, 32'h3F_FFFF)), settings[i]});
			reg_write(3'd4, 32'h0000_0007);                      // no register here
			send_item(OP_VEL, 1, 0, 0);
			send_item(OP_VEL, S32_LO, 0, 0);
			send_item(OP_VEL, -32'sh0008_0000, 0, 0);
			test_random(RANDOM_ITEMS / 5);
		end
	endtask

	// sender holds off until the back end is fully empty, then bursts
	task automatic test_drain_then_burst();
		wait_drained();
		no_idling = 1'b1;
		test_random(40);
		no_idling = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_inv_step_settings();
		test_drain_then_burst();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
hdl/fpra_pkg.sv
hdl/fpra_front.sv
hdl/fpra_queue.sv
hdl/fpra_back.sv
hdl/fixed_point_rne_alu.sv
hdl/fpra_checker.sv
tb/fixed_point_rne_alu_test.sv
